// File: hdl/ctlp_pkg.sv
`timescale 1ns / 1ps

package ctlp_pkg;

  localparam int unsigned VarBitsDefault = 32;
  localparam int unsigned MaxResults     = 3;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueuePtrW      = $clog2(QueueDepth);
  localparam int unsigned QueueCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] ChP       = 8'h70;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChC       = 8'h63;
  localparam logic [7:0] ChN       = 8'h6e;
  localparam logic [7:0] ChF       = 8'h66;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChNewline = 8'h0a;

  typedef enum logic [3:0] {
    LS_START,
    LS_P_WS,
    LS_CN,
    LS_CNF,
    LS_CNT1,
    LS_CNT2,
    LS_BODY,
    LS_COM_START,
    LS_COM_CNT1,
    LS_COM_CNT2,
    LS_COM_BODY,
    LS_NUM_CNT1,
    LS_NUM_CNT2,
    LS_NUM_BODY
  } lex_state_e;

  typedef enum logic [1:0] {
    KIND_LITERAL,
    KIND_CLAUSE_END,
    KIND_END_OF_TEXT,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_EXPECTED_CNF,
    ERR_EXPECTED_COUNT,
    ERR_SYNTAX,
    ERR_OVERFLOW
  } error_code_e;

  typedef struct packed {
    kind_e       kind;
    logic        negated;
    logic [31:0] variable;
    error_code_e error_code;
  } result_t;

  typedef logic [1:0] res_cnt_t;

  // All results caused by one input transaction, oldest in slot zero.
  typedef struct packed {
    res_cnt_t                   cnt;
    result_t [MaxResults-1:0]   res;
  } bundle_t;

  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [QueueCntW-1:0] count;
  } queue_status_t;

  function automatic logic is_ws(logic [7:0] b);
    return (b == ChSpace) || ((b >= ChTab) && (b <= ChCr));
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

  function automatic bundle_t push_result(bundle_t b, kind_e k, logic n,
                                          logic [31:0] v, error_code_e e);
    bundle_t r;
    r = b;
    if (r.cnt != res_cnt_t'(MaxResults)) begin
      r.res[r.cnt] = '{kind: k, negated: n, variable: v, error_code: e};
      r.cnt = r.cnt + 1'b1;
    end
    return r;
  endfunction

endpackage

// File: hdl/ctlp_if.sv
`timescale 1ns / 1ps

interface ctlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  logic       end_of_text;

  modport source (output valid, output byte_req, output end_of_text, input ready);
  modport sink (input valid, input byte_req, input end_of_text, output ready);
endinterface

interface ctlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        negated;
  logic [31:0] variable;
  logic [2:0]  error_code;
  logic        last;

  modport source (output valid, output kind, output negated, output variable,
                  output error_code, output last, input ready);
  modport sink (input valid, input kind, input negated, input variable,
                input error_code, input last, output ready);
endinterface

// File: hdl/cnf_text_literal_parser.sv
`timescale 1ns / 1ps

// DIMACS CNF text parser. Bytes of the text arrive on in_i, one per
// transaction, with end_of_text marking the close of a text (its byte is
// ignored). Parsed results leave on out_o: literals (sign plus variable
// number), clause ends, one end-of-text marker and at most one error per text.
// One input transaction gives zero to three results; the last of them carries
// last = 1. Errors are sticky: after one, bytes are dropped until end_of_text.
// Throughput: one byte per cycle while the queue has room; the lexer step is
// a multiply by ten and add on the number accumulator. Output runs at one
// result per cycle while the receiver is ready; a byte that yields several
// results sends them one after another. Each result group is registered in a
// four-entry queue when its byte is accepted and leaves on out_o from its head;
// the queue separates the lexer from the output serializer, so a stalled
// receiver only stops input once that queue is full. Reset clears the lexer to
// start of file and empties the queue; no results are pending afterwards.
module cnf_text_literal_parser #(
  parameter int unsigned VAR_BITS = ctlp_pkg::VarBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctlp_in_if.sink    in_i,
  ctlp_out_if.source out_o
);

  logic                    push_valid;
  ctlp_pkg::bundle_t       push_bundle;
  ctlp_pkg::bundle_t       head;
  ctlp_pkg::queue_status_t q_status;
  logic                    pop;

  // The lexer takes a byte whenever the queue has room for its results.
  ctlp_front #(
    .VAR_BITS(VAR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_bundle_o(push_bundle),
    .push_ready_i (!q_status.full)
  );

  ctlp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_bundle_i(push_bundle),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // The serializer walks one result group a result at a time.
  ctlp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .status_i(q_status),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // An accepted end of text always produces at least its end marker.
  a_eot_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.end_of_text) |-> push_valid)
    else $error("end of text accepted without a result group");

  // Result groups in the queue are never empty.
  a_group_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (push_bundle.cnt != '0))
    else $error("empty result group pushed");

  // The end-of-text marker is always the final result of its group.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.kind == ctlp_pkg::KIND_END_OF_TEXT)) |-> out_o.last)
    else $error("end-of-text result not marked last");

  // Queue occupancy moves by at most one group per cycle.
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.count == $past(q_status.count)) ||
    (q_status.count == $past(q_status.count) + 1'b1) ||
    (q_status.count == $past(q_status.count) - 1'b1))
    else $error("queue count jumped");

endmodule

// File: hdl/ctlp_front.sv
`timescale 1ns / 1ps

module ctlp_front #(
  parameter int unsigned VAR_BITS = ctlp_pkg::VarBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ctlp_in_if.sink           in_i,
  output logic              push_valid_o,
  output ctlp_pkg::bundle_t push_bundle_o,
  input  logic              push_ready_i
);

  localparam int unsigned WideW = VAR_BITS + 4;

  ctlp_pkg::lex_state_e st_q, st_d;
  logic [VAR_BITS-1:0]  nv_q, nv_d;
  logic [3:0]           dc_q, dc_d;
  logic                 mp_q, mp_d;
  logic                 co_q, co_d;
  logic                 err_q, err_d;
  ctlp_pkg::bundle_t    bnd;

  logic                 accept;
  logic [7:0]           b;
  logic [3:0]           digit;
  logic                 num0;
  logic                 lone;
  logic                 tb_body;
  logic [WideW-1:0]     wide;
  logic [31:0]          var32;

  assign b      = in_i.byte_req;
  assign digit  = b[3:0];  // ASCII digits sit at 0x30..0x39
  assign accept = in_i.valid && push_ready_i;
  assign in_i.ready = push_ready_i;

  assign num0  = (st_q == ctlp_pkg::LS_NUM_CNT1) || (st_q == ctlp_pkg::LS_NUM_CNT2) ||
                 (st_q == ctlp_pkg::LS_NUM_BODY);
  assign lone  = (dc_q == 4'd1) && (nv_q == '0);
  assign wide  = (WideW'(nv_q) << 3) + (WideW'(nv_q) << 1) + WideW'(digit);
  assign var32 = 32'(nv_q);

  always_comb begin
    st_d    = st_q;
    nv_d    = nv_q;
    dc_d    = dc_q;
    mp_d    = mp_q;
    co_d    = co_q;
    err_d   = err_q;
    bnd     = '0;
    tb_body = 1'b0;

    if (!err_q && num0 && !in_i.end_of_text && ctlp_pkg::is_digit(b)) begin
      // Accumulate; anything that spills over the top bits is an overflow.
      if (|wide[WideW-1:VAR_BITS]) begin
        bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                      ctlp_pkg::ERR_OVERFLOW);
        err_d = 1'b1;
      end else begin
        nv_d = wide[VAR_BITS-1:0];
        if (dc_q != 4'd15) dc_d = dc_q + 4'd1;
      end
    end else if (!err_q) begin
      if (num0) begin
        unique case (st_q)
          ctlp_pkg::LS_NUM_CNT1: begin
            if (lone) begin
              bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_EXPECTED_COUNT);
              err_d = 1'b1;
            end else begin
              st_d = ctlp_pkg::LS_CNT2;
            end
          end
          ctlp_pkg::LS_NUM_CNT2: begin
            if (lone) begin
              bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_EXPECTED_COUNT);
              err_d = 1'b1;
            end else begin
              st_d = ctlp_pkg::LS_BODY;
            end
          end
          default: begin
            st_d = ctlp_pkg::LS_BODY;
            if (lone) begin
              if (mp_q) begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_SYNTAX);
                err_d = 1'b1;
              end else begin
                bnd  = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_CLAUSE_END, 1'b0, 32'd0,
                                             ctlp_pkg::ERR_NONE);
                co_d = 1'b0;
              end
            end else begin
              bnd  = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_LITERAL, mp_q, var32,
                                           ctlp_pkg::ERR_NONE);
              co_d = 1'b1;
              mp_d = 1'b0;
            end
          end
        endcase
        nv_d = '0;
        dc_d = '0;
      end

      if (!err_d) begin
        if (in_i.end_of_text) begin
          unique case (st_d)
            ctlp_pkg::LS_P_WS, ctlp_pkg::LS_CN, ctlp_pkg::LS_CNF: begin
              bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_EXPECTED_CNF);
              err_d = 1'b1;
            end
            ctlp_pkg::LS_CNT1, ctlp_pkg::LS_CNT2,
            ctlp_pkg::LS_COM_CNT1, ctlp_pkg::LS_COM_CNT2: begin
              bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_EXPECTED_COUNT);
              err_d = 1'b1;
            end
            default: begin
              if (mp_d) begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_SYNTAX);
                err_d = 1'b1;
              end else if (co_d) begin
                bnd = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_CLAUSE_END, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_NONE);
              end
            end
          endcase
        end else begin
          unique case (st_d)
            ctlp_pkg::LS_START: begin
              if (ctlp_pkg::is_ws(b)) begin
                st_d = st_d;
              end else if (b == ctlp_pkg::ChC) begin
                st_d = ctlp_pkg::LS_COM_START;
              end else if (b == ctlp_pkg::ChP) begin
                st_d = ctlp_pkg::LS_P_WS;
              end else begin
                tb_body = 1'b1;
              end
            end
            ctlp_pkg::LS_P_WS: begin
              if (ctlp_pkg::is_ws(b)) begin
                st_d = st_d;
              end else if (b == ctlp_pkg::ChC) begin
                st_d = ctlp_pkg::LS_CN;
              end else begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_EXPECTED_CNF);
                err_d = 1'b1;
              end
            end
            ctlp_pkg::LS_CN: begin
              if (b == ctlp_pkg::ChN) begin
                st_d = ctlp_pkg::LS_CNF;
              end else begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_EXPECTED_CNF);
                err_d = 1'b1;
              end
            end
            ctlp_pkg::LS_CNF: begin
              if (b == ctlp_pkg::ChF) begin
                st_d = ctlp_pkg::LS_CNT1;
              end else begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_EXPECTED_CNF);
                err_d = 1'b1;
              end
            end
            ctlp_pkg::LS_CNT1, ctlp_pkg::LS_CNT2: begin
              if (ctlp_pkg::is_ws(b)) begin
                st_d = st_d;
              end else if (b == ctlp_pkg::ChC) begin
                st_d = (st_d == ctlp_pkg::LS_CNT1) ? ctlp_pkg::LS_COM_CNT1
                                                   : ctlp_pkg::LS_COM_CNT2;
              end else if (ctlp_pkg::is_digit(b)) begin
                nv_d = VAR_BITS'(digit);
                dc_d = 4'd1;
                st_d = (st_d == ctlp_pkg::LS_CNT1) ? ctlp_pkg::LS_NUM_CNT1
                                                   : ctlp_pkg::LS_NUM_CNT2;
              end else begin
                bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                              ctlp_pkg::ERR_EXPECTED_COUNT);
                err_d = 1'b1;
              end
            end
            ctlp_pkg::LS_COM_START: if (b == ctlp_pkg::ChNewline) st_d = ctlp_pkg::LS_START;
            ctlp_pkg::LS_COM_CNT1:  if (b == ctlp_pkg::ChNewline) st_d = ctlp_pkg::LS_CNT1;
            ctlp_pkg::LS_COM_CNT2:  if (b == ctlp_pkg::ChNewline) st_d = ctlp_pkg::LS_CNT2;
            ctlp_pkg::LS_COM_BODY:  if (b == ctlp_pkg::ChNewline) st_d = ctlp_pkg::LS_BODY;
            default: tb_body = 1'b1;
          endcase

          // Body token handling, shared by the first token and the clause body.
          if (tb_body) begin
            st_d = ctlp_pkg::LS_BODY;
            if (ctlp_pkg::is_ws(b)) begin
              st_d = ctlp_pkg::LS_BODY;
            end else if (b == ctlp_pkg::ChC) begin
              st_d = ctlp_pkg::LS_COM_BODY;
            end else if (ctlp_pkg::is_digit(b)) begin
              nv_d = VAR_BITS'(digit);
              dc_d = 4'd1;
              st_d = ctlp_pkg::LS_NUM_BODY;
            end else if ((b == ctlp_pkg::ChMinus) && !mp_d) begin
              mp_d = 1'b1;
            end else begin
              bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_ERROR, 1'b0, 32'd0,
                                            ctlp_pkg::ERR_SYNTAX);
              err_d = 1'b1;
            end
          end
        end
      end
    end

    if (in_i.end_of_text) begin
      bnd   = ctlp_pkg::push_result(bnd, ctlp_pkg::KIND_END_OF_TEXT, 1'b0, 32'd0,
                                    ctlp_pkg::ERR_NONE);
      st_d  = ctlp_pkg::LS_START;
      nv_d  = '0;
      dc_d  = '0;
      mp_d  = 1'b0;
      co_d  = 1'b0;
      err_d = 1'b0;
    end
  end

  assign push_valid_o  = accept && (bnd.cnt != '0);
  assign push_bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ctlp_pkg::LS_START;
      nv_q  <= '0;
      dc_q  <= '0;
      mp_q  <= 1'b0;
      co_q  <= 1'b0;
      err_q <= 1'b0;
    end else if (accept) begin
      st_q  <= st_d;
      nv_q  <= nv_d;
      dc_q  <= dc_d;
      mp_q  <= mp_d;
      co_q  <= co_d;
      err_q <= err_d;
    end
  end

endmodule

// File: hdl/ctlp_queue.sv
`timescale 1ns / 1ps

module ctlp_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  ctlp_pkg::bundle_t       push_bundle_i,
  input  logic                    pop_i,
  output ctlp_pkg::bundle_t       head_o,
  output ctlp_pkg::queue_status_t status_o
);

  localparam logic [ctlp_pkg::QueuePtrW-1:0] LastPtr =
    ctlp_pkg::QueuePtrW'(ctlp_pkg::QueueDepth - 1);
  localparam logic [ctlp_pkg::QueueCntW-1:0] FullCnt =
    ctlp_pkg::QueueCntW'(ctlp_pkg::QueueDepth);

  ctlp_pkg::bundle_t                mem_q [ctlp_pkg::QueueDepth];
  logic [ctlp_pkg::QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [ctlp_pkg::QueueCntW-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.count = cnt_q;
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ctlp_back.sv
`timescale 1ns / 1ps

module ctlp_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctlp_pkg::bundle_t       head_i,
  input  ctlp_pkg::queue_status_t status_i,
  output logic                    pop_o,
  ctlp_out_if.source              out_o
);

  ctlp_pkg::res_cnt_t sub_q, sub_d;
  ctlp_pkg::result_t  sel;
  logic               is_last;
  logic               fire;

  assign sel     = head_i.res[sub_q];
  assign is_last = (sub_q == (head_i.cnt - 1'b1));
  assign fire    = out_o.valid && out_o.ready;

  assign out_o.valid      = !status_i.empty;
  assign out_o.kind       = sel.kind;
  assign out_o.negated    = sel.negated;
  assign out_o.variable   = sel.variable;
  assign out_o.error_code = sel.error_code;
  assign out_o.last       = is_last;

  assign pop_o = fire && is_last;

  always_comb begin
    sub_d = sub_q;
    if (fire) sub_d = is_last ? '0 : sub_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule
